// ===== rtl/mvpt_pkg.sv =====
`timescale 1ns / 1ps

package mvpt_pkg;

   localparam int unsigned TBL_ENTRIES = 256;
   localparam int unsigned IDX_W       = $clog2(TBL_ENTRIES);
   localparam int unsigned FILL_W      = IDX_W + 1;
   localparam int unsigned USED_OUT_W  = 9;
   localparam int unsigned VAL_W       = 64;
   localparam int unsigned CNT_W       = 32;
   localparam int unsigned TYPE_W      = 2;

   localparam logic [CNT_W-1:0]  CNT_MAX = 32'hFFFF_FFFF;
   localparam logic [VAL_W-1:0]  LOW32   = 64'h0000_0000_FFFF_FFFF;

   localparam logic [TYPE_W-1:0] VT_INT32   = 2'd0;
   localparam logic [TYPE_W-1:0] VT_FLOAT32 = 2'd1;
   localparam logic [TYPE_W-1:0] VT_FLOAT64 = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } seq_state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_nan(input logic [TYPE_W-1:0] vt, input logic [VAL_W-1:0] v);
      logic r;
      r = 1'b0;
      if (vt == VT_FLOAT32) begin
         r = (v[30:23] == 8'hFF) && (v[22:0] != '0);
      end else if (vt == VT_FLOAT64) begin
         r = (v[62:52] == 11'h7FF) && (v[51:0] != '0);
      end
      is_nan = r;
   endfunction

endpackage

// ===== rtl/mvpt_key_match.sv =====
`timescale 1ns / 1ps

module mvpt_key_match (
   input  logic [mvpt_pkg::TYPE_W-1:0] value_type,
   input  logic [mvpt_pkg::VAL_W-1:0]  stored_key,
   input  logic [mvpt_pkg::VAL_W-1:0]  probe_key,
   output logic                        match
);
   import mvpt_pkg::*;

   logic any_nan;
   logic both_zero;

   always_comb begin
      any_nan   = is_nan(value_type, stored_key) || is_nan(value_type, probe_key);
      // +0 and -0 compare equal for doubles
      both_zero = (value_type == VT_FLOAT64) && (stored_key[VAL_W-2:0] == '0)
                  && (probe_key[VAL_W-2:0] == '0);
      match     = !any_nan && (both_zero || (stored_key == probe_key));
   end

endmodule

// ===== rtl/memo_value_profile_table_unit.sv =====
`timescale 1ns / 1ps

// value profiler for one memoizable function: each transaction carries a call's argument and
// result; the block counts the call, searches its 256-entry table for the argument and either
// bumps the matching entry's counter or appends a new entry (or flags a drop when full), then
// returns one result transaction with the entry and running totals. the search walks the
// occupied entries one per cycle through a single read port of the key memory and one shared
// key comparator; req_tready stays low from acceptance until the result is loaded into the
// output register, so one item is profiled at a time. value_type is to be written through
// csr_wen/csr_wdata only while the block is idle; the block itself does not enforce this.

module memo_value_profile_table_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [mvpt_pkg::TYPE_W-1:0] csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // arg_value [63:0], ret_value [127:64]
   input  logic [127:0]                req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // entry_count_value [31:0], stored_result [95:32], total_calls [127:96],
   // total_hits [159:128], entries_used [168:160], zero fill [175:169]
   output logic [175:0]                rsp_tdata,
   // hit [0], dropped [1]
   output logic [1:0]                  rsp_tuser
);
   import mvpt_pkg::*;

   logic [VAL_W-1:0] key_mem [TBL_ENTRIES];
   logic [VAL_W-1:0] res_mem [TBL_ENTRIES];
   logic [CNT_W-1:0] cnt_mem [TBL_ENTRIES];

   seq_state_type     state_ff, state_in;
   logic [TYPE_W-1:0] vtype_ff;
   logic [FILL_W-1:0] used_ff;
   logic [FILL_W-1:0] scan_addr_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_valid_ff;
   logic              found_ff;
   logic [CNT_W-1:0]  calls_ff;
   logic [CNT_W-1:0]  hits_ff;
   logic [VAL_W-1:0]  key_ff;
   logic [VAL_W-1:0]  ret_ff;
   logic [VAL_W-1:0]  key_rd_ff;
   logic [VAL_W-1:0]  res_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;

   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  o_cnt_ff;
   logic [VAL_W-1:0]  o_res_ff;
   logic [CNT_W-1:0]  o_calls_ff;
   logic [CNT_W-1:0]  o_hits_ff;
   logic [FILL_W-1:0] o_used_ff;
   logic              o_hit_ff;
   logic              o_drop_ff;

   logic              accept;
   logic              match;
   logic              hit_now;
   logic              last_cmp;
   logic              issue;
   logic              out_free;
   logic              finish_go;
   logic              full;
   logic              mem_we;
   logic              wide_in;
   logic [CNT_W-1:0]  hit_cnt;

   mvpt_key_match u_match (
      .value_type (vtype_ff),
      .stored_key (key_rd_ff),
      .probe_key  (key_ff),
      .match      (match)
   );

   assign accept   = req_tvalid && req_tready;
   assign hit_now  = cmp_valid_ff && match;
   assign last_cmp = cmp_valid_ff && (({1'b0, cmp_idx_ff} + 1'b1) == used_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = (used_ff == FILL_W'(TBL_ENTRIES));
   assign wide_in  = (vtype_ff == VT_FLOAT64);
   assign hit_cnt  = sat_inc(cnt_rd_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (used_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_now || last_cmp) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      finish_go  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   issue      = (scan_addr_ff < used_ff) && !hit_now;
         ST_FINISH: finish_go  = out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign mem_we = finish_go && !found_ff && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vtype_ff     <= VT_INT32;
         used_ff      <= '0;
         scan_addr_ff <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         calls_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            vtype_ff <= csr_wdata;
         end
         if (accept) begin
            calls_ff     <= sat_inc(calls_ff);
            scan_addr_ff <= '0;
            found_ff     <= 1'b0;
         end else if (issue) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
         cmp_valid_ff <= issue;
         if (hit_now) begin
            found_ff <= 1'b1;
         end
         if (mem_we) begin
            used_ff <= used_ff + 1'b1;
         end
         if (finish_go && found_ff) begin
            hits_ff <= sat_inc(hits_ff);
         end
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= wide_in ? req_tdata[63:0] : (req_tdata[63:0] & LOW32);
         ret_ff <= wide_in ? req_tdata[127:64] : (req_tdata[127:64] & LOW32);
      end
      if (issue) begin
         cmp_idx_ff <= scan_addr_ff[IDX_W-1:0];
      end
      if (finish_go) begin
         o_hit_ff   <= found_ff;
         o_drop_ff  <= !found_ff && full;
         o_calls_ff <= calls_ff;
         o_hits_ff  <= found_ff ? sat_inc(hits_ff) : hits_ff;
         o_used_ff  <= mem_we ? used_ff + 1'b1 : used_ff;
         if (found_ff) begin
            o_cnt_ff <= hit_cnt;
            o_res_ff <= res_rd_ff;
         end else if (full) begin
            o_cnt_ff <= '0;
            o_res_ff <= '0;
         end else begin
            o_cnt_ff <= CNT_W'(1);
            o_res_ff <= ret_ff;
         end
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (issue) begin
         key_rd_ff <= key_mem[scan_addr_ff[IDX_W-1:0]];
         res_rd_ff <= res_mem[scan_addr_ff[IDX_W-1:0]];
         cnt_rd_ff <= cnt_mem[scan_addr_ff[IDX_W-1:0]];
      end
      if (mem_we) begin
         key_mem[used_ff[IDX_W-1:0]] <= key_ff;
         res_mem[used_ff[IDX_W-1:0]] <= ret_ff;
         cnt_mem[used_ff[IDX_W-1:0]] <= CNT_W'(1);
      end else if (finish_go && found_ff) begin
         cnt_mem[cmp_idx_ff] <= hit_cnt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {o_drop_ff, o_hit_ff};
   assign rsp_tdata  = {7'd0, USED_OUT_W'(o_used_ff), o_hits_ff, o_calls_ff, o_res_ff, o_cnt_ff};

   a_used_never_drops: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> used_ff >= $past(used_ff))
      else $error("fill count decreased");

   a_append_not_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> used_ff < FILL_W'(TBL_ENTRIES))
      else $error("append into a full table");

   a_hit_drop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(o_hit_ff && o_drop_ff))
      else $error("result both hit and dropped");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> {1'b0, cmp_idx_ff} < used_ff)
      else $error("compare on an unused entry");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      (finish_go && !found_ff && !full) |=> o_used_ff == used_ff && !o_drop_ff)
      else $error("append not reflected in result");

endmodule

// ===== sim/memo_value_profile_table_unit_test.sv =====
`timescale 1ns / 1ps

module memo_value_profile_table_unit_test;
   import mvpt_pkg::*;

   localparam logic [TYPE_W-1:0] VT_SPARE = 2'd3;

   // arg in the low half, as on req_tdata
   typedef struct packed {
      logic [63:0] ret;
      logic [63:0] arg;
   } call_type;

   // same order as {rsp_tuser, rsp_tdata}
   typedef struct packed {
      logic        dropped;
      logic        hit;
      logic [6:0]  fill;
      logic [8:0]  used;
      logic [31:0] hits;
      logic [31:0] calls;
      logic [63:0] kept;
      logic [31:0] count;
   } profile_type;

   typedef enum {
      RDY_FLOW,
      RDY_CHOPPY,
      RDY_HELD,
      RDY_TOGGLE
   } ready_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wen = 1'b0;
   logic [TYPE_W-1:0]   csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [127:0]        req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [175:0]        rsp_tdata;
   logic [1:0]          rsp_tuser;

   // profiler image
   logic [TYPE_W-1:0]   cur_type = VT_INT32;
   logic [63:0]         key_tab [TBL_ENTRIES];
   logic [63:0]         res_tab [TBL_ENTRIES];
   logic [31:0]         cnt_tab [TBL_ENTRIES];
   int unsigned         used_count = 0;
   logic [31:0]         call_count = '0;
   logic [31:0]         hit_count = '0;

   call_type            pending_calls [$];
   profile_type         expected_profiles [$];
   logic [63:0]         seen_args [$];
   bit                  call_taken = 1'b0;
   int                  burst_left = 1;
   int                  gap_left = 0;
   ready_mode_type      ready_mode = RDY_FLOW;
   int                  ready_left = 0;
   int                  errors = 0;
   profile_type         got_profile;
   profile_type         want_profile;

   memo_value_profile_table_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] count_up(input logic [31:0] v);
      return (v == CNT_MAX) ? v : v + 32'd1;
   endfunction

   function automatic bit nan_key(input logic [63:0] v);
      case (cur_type)
         VT_FLOAT32: return (&v[30:23]) && (|v[22:0]);
         VT_FLOAT64: return (&v[62:52]) && (|v[51:0]);
         default:    return 1'b0;
      endcase
   endfunction

   function automatic bit keys_equal(input logic [63:0] stored, input logic [63:0] probe);
      if (nan_key(stored) || nan_key(probe)) return 1'b0;
      // float64 compares +0 and -0 equal
      if (cur_type == VT_FLOAT64 && stored[62:0] == '0 && probe[62:0] == '0) return 1'b1;
      return stored == probe;
   endfunction

   function automatic profile_type profile_call(input logic [63:0] arg_raw,
                                                input logic [63:0] ret_raw);
      profile_type r;
      logic [63:0] key;
      logic [63:0] res;
      int          idx;
      bit          found;
      r     = '0;
      found = 1'b0;
      idx   = 0;
      key   = (cur_type == VT_FLOAT64) ? arg_raw : (arg_raw & LOW32);
      res   = (cur_type == VT_FLOAT64) ? ret_raw : (ret_raw & LOW32);
      call_count = count_up(call_count);
      for (int i = 0; i < used_count; i++) begin
         if (!found && keys_equal(key_tab[i], key)) begin
            found = 1'b1;
            idx   = i;
         end
      end
      if (found) begin
         hit_count    = count_up(hit_count);
         cnt_tab[idx] = count_up(cnt_tab[idx]);
         r.hit        = 1'b1;
         r.count      = cnt_tab[idx];
         r.kept       = res_tab[idx];
      end else if (used_count < TBL_ENTRIES) begin
         key_tab[used_count] = key;
         res_tab[used_count] = res;
         cnt_tab[used_count] = 32'd1;
         used_count++;
         r.count = 32'd1;
         r.kept  = res;
      end else begin
         r.dropped = 1'b1;
      end
      r.calls = call_count;
      r.hits  = hit_count;
      r.used  = used_count[8:0];
      return r;
   endfunction

   function automatic logic [63:0] fresh_arg();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0: v[63:32] = '0;
         1: begin
            v[30:23] = 8'hFF;
            if (v[22:0] == '0) v[0] = 1'b1;
         end
         2: begin
            v[62:52] = 11'h7FF;
            if (v[51:0] == '0) v[0] = 1'b1;
         end
         3: begin
            case (v[1:0])
               2'd0: v = '0;
               2'd1: v = 64'h8000_0000_0000_0000;
               2'd2: v = 64'h0000_0000_8000_0000;
               default: v[31:0] = '0;
            endcase
         end
         4: begin
            case (v[1:0])
               2'd0: v = 64'h0000_0000_7F80_0000;
               2'd1: v = 64'h0000_0000_FF80_0000;
               2'd2: v = 64'h7FF0_0000_0000_0000;
               default: v = 64'hFFF0_0000_0000_0000;
            endcase
         end
         5: begin
            if (v[0]) v = '1;
            else v[31:0] = '1;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_call(input logic [63:0] arg, input logic [63:0] ret);
      call_type c;
      c.arg = arg;
      c.ret = ret;
      pending_calls.push_back(c);
   endtask

   task automatic add_random_call();
      logic [63:0] arg;
      logic [63:0] ret;
      int          pick;
      int          span;
      pick = $urandom_range(99);
      ret  = {$urandom, $urandom};
      if ($urandom_range(15) == 0) ret = $urandom_range(1) ? '1 : '0;
      if (pick < 55 && seen_args.size() > 0) begin
         arg = seen_args[$urandom_range(seen_args.size() - 1)];
      end else if (pick < 82 && seen_args.size() > 0) begin
         span = (seen_args.size() > 16) ? 15 : seen_args.size() - 1;
         arg  = seen_args[seen_args.size() - 1 - $urandom_range(span)];
      end else begin
         arg = fresh_arg();
         seen_args.push_back(arg);
      end
      // upper half is don't-care for 32-bit keys, sign is don't-care for float64 zero
      if (cur_type != VT_FLOAT64 && $urandom_range(3) == 0) arg[63:32] = $urandom;
      if (cur_type == VT_FLOAT64 && arg[62:0] == '0 && $urandom_range(1)) arg[63] = ~arg[63];
      add_call(arg, ret);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_calls.size() != 0 || req_tvalid || expected_profiles.size() != 0);
   endtask

   task automatic set_value_type(input logic [TYPE_W-1:0] vt);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= vt;
      @(negedge clock);
      csr_wen  <= 1'b0;
      cur_type  = vt;
   endtask

   // sender: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || call_taken) begin
         call_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_calls.size() > 0) begin
            req_tdata  <= pending_calls.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(9) == 0) begin
               burst_left = $urandom_range(80, 30);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(6, 1);
               gap_left   = $urandom_range(10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(3));
         ready_left = (ready_mode == RDY_HELD) ? $urandom_range(12, 1) : $urandom_range(300, 20);
      end
      ready_left--;
      case (ready_mode)
         RDY_FLOW:   rsp_tready <= 1'b1;
         RDY_CHOPPY: rsp_tready <= ($urandom_range(2) != 0);
         RDY_HELD:   rsp_tready <= 1'b0;
         default:    rsp_tready <= ready_left[0];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_profiles.push_back(profile_call(req_tdata[63:0], req_tdata[127:64]));
         call_taken = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_profile = {rsp_tuser, rsp_tdata};
         if (expected_profiles.size() == 0) begin
            errors++;
            $display("%0t unexpected result transaction: %h", $time, got_profile);
         end else begin
            want_profile = expected_profiles.pop_front();
            if (got_profile !== want_profile) begin
               errors++;
               $display("%0t expected hit=%0b drop=%0b cnt=%0d kept=%h calls=%0d hits=%0d",
                        $time, want_profile.hit, want_profile.dropped, want_profile.count,
                        want_profile.kept, want_profile.calls, want_profile.hits);
               $display("   used=%0d fill=%h", want_profile.used, want_profile.fill);
               $display("%0t actual   hit=%0b drop=%0b cnt=%0d kept=%h calls=%0d hits=%0d",
                        $time, got_profile.hit, got_profile.dropped, got_profile.count,
                        got_profile.kept, got_profile.calls, got_profile.hits);
               $display("   used=%0d fill=%h", got_profile.used, got_profile.fill);
            end
         end
      end
   end

   initial begin
      #15_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [TYPE_W-1:0] phase_types [8];
      phase_types = '{VT_INT32, VT_FLOAT64, VT_FLOAT32, VT_SPARE,
                      VT_FLOAT64, VT_INT32, VT_FLOAT32, VT_FLOAT64};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // int32: upper halves ignored
      set_value_type(VT_INT32);
      add_call(64'h0, 64'h0);
      add_call('1, '1);
      add_call(64'hABCD_0000_0000_0000, 64'h1111_2222_3333_4444);
      add_call(64'h1234_5678_FFFF_FFFF, 64'h0);

      // float32: nan always misses, signed zeros are distinct
      set_value_type(VT_FLOAT32);
      add_call(64'h0000_0000_7FC0_0000, 64'h0000_0000_3F80_0000);
      add_call(64'h0000_0000_7FC0_0000, 64'h0000_0000_4000_0000);
      add_call(64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000);
      add_call(64'h0, 64'h5);
      add_call(64'h0000_0000_7F80_0000, 64'h0000_0000_0000_0007);
      add_call(64'h0000_0000_7F80_0000, 64'h0);

      // float64: old entries compared under the new type, -0 equals +0
      set_value_type(VT_FLOAT64);
      add_call(64'h8000_0000_0000_0000, 64'h0);
      add_call(64'h0, '1);
      add_call(64'h7FF8_0000_0000_0001, 64'h3FF0_0000_0000_0000);
      add_call(64'h7FF8_0000_0000_0001, 64'h4000_0000_0000_0000);
      add_call(64'h0000_0000_7FC0_0000, 64'h0);
      add_call('1, 64'hDEAD_BEEF_0000_0001);
      add_call(64'h7FF0_0000_0000_0000, 64'h8000_0000_0000_0000);
      add_call(64'h7FF0_0000_0000_0000, 64'h0);

      // spare code behaves as int32
      set_value_type(VT_SPARE);
      add_call(64'h0000_0000_7FC0_0000, 64'h0);
      add_call(64'hFFFF_FFFF_0000_0000, 64'h0);
      add_call(64'h0000_0000_FFFF_FFFF, '1);

      foreach (phase_types[p]) begin
         set_value_type(phase_types[p]);
         repeat (250) add_random_call();
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (expected_profiles.size() != 0) errors++;
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
